// ----- rtl/cha_pkg.sv -----
// shared types and constants for the three-axis channel averager
`timescale 1ns / 1ps

package cha_pkg;

    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam int SUM_W  = 32;
    localparam int OUT_W  = 24;
    localparam int USER_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [1:0] CH_X   = 2'd0;
    localparam logic [1:0] CH_REF = 2'd1;
    localparam logic [1:0] CH_Y   = 2'd2;
    localparam logic [1:0] CH_Z   = 2'd3;

    typedef logic [AXIS_W-1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef struct packed {
        logic  is_read;
        axis_t axis;
    } cha_item_t;

endpackage

// ----- rtl/cha_front.sv -----
// input side: takes transactions, maps channels to axes, drops reference samples, queues items
`timescale 1ns / 1ps

module cha_front
    import cha_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int DATA_W      = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,
    input  logic [USER_W-1:0]      s_axis_tuser,
    output logic                   item_valid,
    input  logic                   item_ready,
    output cha_item_t              item,
    output logic [SAMPLE_BITS-1:0] item_sample
);

    cha_item_t              item_q [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] sample_q [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic      in_mode;
    logic [1:0] in_channel;
    logic      is_ref;
    logic      push;
    logic      pop;
    cha_item_t in_item;

    assign in_mode    = s_axis_tuser[0];
    assign in_channel = s_axis_tuser[2:1];

    always_comb begin
        in_item.is_read = (in_mode == MODE_READ);
        case (in_channel)
            CH_X:    in_item.axis = AXIS_X;
            CH_Y:    in_item.axis = AXIS_Y;
            CH_Z:    in_item.axis = AXIS_Z;
            default: in_item.axis = AXIS_X;
        endcase
    end

    // reference samples change nothing, so they never enter the queue
    assign is_ref = (in_mode == MODE_SAMPLE) && (in_channel == CH_REF);

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && !is_ref;
    assign item_valid    = (count_reg != '0);
    assign pop           = item_valid && item_ready;
    assign item          = item_q[rd_ptr_reg];
    assign item_sample   = sample_q[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_q[wr_ptr_reg]   <= in_item;
            sample_q[wr_ptr_reg] <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- rtl/cha_divider.sv -----
// serial restoring divider, one quotient bit per cycle, with saturation to the output width
`timescale 1ns / 1ps

module cha_divider
    import cha_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] sum,
    input  logic [SUM_W-1:0] den,
    output logic             done,
    output logic [OUT_W-1:0] quot
);

    localparam int NUM_W = SUM_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SUM_W:0]   rem_shift;
    logic [SUM_W:0]   rem_diff;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= NUM_W'(sum) << FRACTION_BITS;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = (|quo_reg[NUM_W-1:OUT_W]) ? OUT_MAX : quo_reg[OUT_W-1:0];

endmodule

// ----- rtl/cha_back.sv -----
// execution side: axis accumulators, read snapshot, division sequence and result register
`timescale 1ns / 1ps

module cha_back
    import cha_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  cha_item_t              item,
    input  logic [SAMPLE_BITS-1:0] item_sample,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [3*OUT_W-1:0]     m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg;

    logic [SUM_W-1:0] sum_reg  [AXES];
    logic [SUM_W-1:0] cnt_reg  [AXES];
    logic [SUM_W-1:0] snap_sum_reg [AXES];
    logic [SUM_W-1:0] snap_cnt_reg [AXES];
    logic [OUT_W-1:0] quot_reg [AXES];

    axis_t              sel_reg;
    logic               start_reg;
    logic               out_valid_reg;
    logic [3*OUT_W-1:0] out_data_reg;

    logic             pop;
    logic             read_pop;
    logic             sample_pop;
    logic             div_done;
    logic [OUT_W-1:0] div_quot;
    logic [SUM_W-1:0] div_den;
    logic             out_load;

    // samples keep flowing while a read is being divided; a new read waits
    assign item_ready = !item.is_read || (state_reg == ST_IDLE);
    assign pop        = item_valid && item_ready;
    assign read_pop   = pop && item.is_read;
    assign sample_pop = pop && !item.is_read;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // an empty axis divides by one
    assign div_den = (snap_cnt_reg[sel_reg] == '0) ? SUM_W'(1) : snap_cnt_reg[sel_reg];

    cha_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .sum     (snap_sum_reg[sel_reg]),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sel_reg       <= AXIS_X;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                sum_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end else begin
            start_reg <= ((state_reg == ST_IDLE) && read_pop)
                      || ((state_reg == ST_DIV) && div_done
                          && (sel_reg != AXIS_W'(AXES - 1)));
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);
            if (sample_pop) begin
                sum_reg[item.axis] <= sum_reg[item.axis] + SUM_W'(item_sample);
                cnt_reg[item.axis] <= cnt_reg[item.axis] + 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (read_pop) begin
                        for (int k = 0; k < AXES; k++) begin
                            sum_reg[k] <= '0;
                            cnt_reg[k] <= '0;
                        end
                        sel_reg   <= AXIS_X;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (sel_reg == AXIS_W'(AXES - 1)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (read_pop && (state_reg == ST_IDLE)) begin
            for (int k = 0; k < AXES; k++) begin
                snap_sum_reg[k] <= sum_reg[k];
                snap_cnt_reg[k] <= cnt_reg[k];
            end
        end
        if ((state_reg == ST_DIV) && div_done) begin
            quot_reg[sel_reg] <= div_quot;
        end
        if (out_load) begin
            out_data_reg <= {quot_reg[2], quot_reg[1], quot_reg[0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/three_axis_channel_averager.sv -----
// top level of the three-axis channel averager: input queue, accumulators and divider
//
//  channel | direction | tdata (low bit up)        | tuser (low bit up)
//  s_axis  | in        | sample                    | mode, channel[1:0]
//  m_axis  | out       | avg_x, avg_y, avg_z       | -
//
//  a sample transaction is absorbed while the queue has room; the four-entry queue feeds the accumulators
//  an accepted read divides the snapshot of each axis in turn, x, y then z, and then shows its result on m_axis
//  samples behind a read keep accumulating during the division; a second read waits
//  aresetn clears sums, counts, queue and sequencer at once, no clearing pass
//  a result held on m_axis stalls the read after next at the queue head, and samples behind it wait
`timescale 1ns / 1ps

module three_axis_channel_averager
    import cha_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8,
    parameter int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,   // sample
    input  logic [USER_W-1:0]  s_axis_tuser,   // mode, channel
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [3*OUT_W-1:0] m_axis_tdata    // avg_x, avg_y, avg_z
);

    logic                   item_valid;
    logic                   item_ready;
    cha_item_t              item;
    logic [SAMPLE_BITS-1:0] item_sample;

    cha_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DATA_W      (DATA_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .item_sample   (item_sample)
    );

    cha_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .item_sample   (item_sample),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- dv/three_axis_channel_averager_tb.sv -----
// self-checking stream testbench for the three-axis channel averager
`timescale 1ns / 1ps

module three_axis_channel_averager_tb;
    import cha_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 16;
    localparam int RAND_ITEMS    = 830;
    localparam int HOLD_CYCLES   = 600;
    localparam int QUIET_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 200;
    localparam int DIR_N         = 21;

    typedef struct packed {
        logic [OUT_W-1:0] avg_z;
        logic [OUT_W-1:0] avg_y;
        logic [OUT_W-1:0] avg_x;
    } avg_set_t;

    typedef struct packed {
        logic             mode;
        logic [1:0]       chan;
        logic [15:0]      smp;
        logic             typed;
        logic [OUT_W-1:0] ex_x;
        logic [OUT_W-1:0] ex_y;
        logic [OUT_W-1:0] ex_z;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata;   // sample
    logic [USER_W-1:0]  s_axis_tuser;   // mode, channel
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [3*OUT_W-1:0] m_axis_tdata;   // avg_x, avg_y, avg_z

    logic [SUM_W-1:0] acc_sum [AXES];
    logic [SUM_W-1:0] acc_cnt [AXES];
    avg_set_t         pending_avgs [$];

    int  mismatches;
    int  hold_req;
    int  hold_served;
    bit  idle_on;

    stim_row_t dir_rows [DIR_N] = '{
        '{MODE_READ,   CH_X,   16'h0000, 1'b1, 24'h000000, 24'h000000, 24'h000000},
        '{MODE_SAMPLE, CH_X,   16'hFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_X,   16'h0000, 1'b1, 24'hFFFF00, 24'h000000, 24'h000000},
        '{MODE_SAMPLE, CH_REF, 16'h1234, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_Z,   16'hFFFF, 1'b1, 24'h000000, 24'h000000, 24'h000000},
        '{MODE_SAMPLE, CH_X,   16'h0000, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Y,   16'hFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Z,   16'h0001, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Z,   16'h0002, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Y,   16'h0000, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_REF, 16'h0000, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_Y,   16'hAAAA, 1'b1, 24'h000000, 24'h000000, 24'h000000},
        '{MODE_SAMPLE, CH_Z,   16'hFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Z,   16'hFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Z,   16'hFFFE, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_X,   16'h5555, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Y,   16'hAAAA, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_REF, 16'hFFFF, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_X,   16'h0000, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_SAMPLE, CH_Y,   16'h0001, 1'b0, 24'h0, 24'h0, 24'h0},
        '{MODE_READ,   CH_Z,   16'h0000, 1'b1, 24'h000000, 24'h000100, 24'h000000}
    };

    three_axis_channel_averager #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [OUT_W-1:0] axis_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [SUM_W-1:0] cnt);
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] quo;
        den = (cnt == '0) ? 64'd1 : {32'd0, cnt};
        num = {32'd0, sum} << FRACTION_BITS;
        quo = num / den;
        return (quo > {40'd0, OUT_MAX}) ? OUT_MAX : quo[OUT_W-1:0];
    endfunction

    // advances the accumulator copy and returns the averages a read would give
    function automatic avg_set_t accumulate(input logic mode, input logic [1:0] chan,
                                            input logic [15:0] smp);
        avg_set_t avgs;
        int       k;
        avgs = '0;
        if (mode == MODE_SAMPLE) begin
            if (chan != CH_REF) begin
                k = (chan == CH_X) ? 0 : int'(chan) - 1;
                acc_sum[k] = acc_sum[k] + SUM_W'(smp);
                acc_cnt[k] = acc_cnt[k] + 1;
            end
        end else begin
            avgs.avg_x = axis_mean(acc_sum[AXIS_X], acc_cnt[AXIS_X]);
            avgs.avg_y = axis_mean(acc_sum[AXIS_Y], acc_cnt[AXIS_Y]);
            avgs.avg_z = axis_mean(acc_sum[AXIS_Z], acc_cnt[AXIS_Z]);
            for (int i = 0; i < AXES; i++) begin
                acc_sum[i] = '0;
                acc_cnt[i] = '0;
            end
        end
        return avgs;
    endfunction

    // offers one transaction, with an optional idle burst first
    task automatic send_item(input logic mode, input logic [1:0] chan, input logic [15:0] smp,
                             input bit typed, input avg_set_t typed_avgs);
        avg_set_t avgs;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tuser  = {chan, mode};
        do @(posedge aclk); while (!s_axis_tready);
        avgs = accumulate(mode, chan, smp);
        if (mode == MODE_READ)
            pending_avgs.push_back(typed ? typed_avgs : avgs);
    endtask

    task automatic send_random(input int read_odds);
        logic [15:0] smp;
        logic [1:0]  chan;
        logic        mode;
        mode = ($urandom_range(1, read_odds) == 1) ? MODE_READ : MODE_SAMPLE;
        chan = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0: smp = 16'h0000;
            1: smp = 16'hFFFF;
            default: smp = 16'($urandom_range(0, 65535));
        endcase
        send_item(mode, chan, smp, 1'b0, '0);
    endtask

    // receiver side: long hold-off on request, otherwise random short stalls
    initial begin
        m_axis_tready = 1'b0;
        hold_served   = 0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served = hold_served + 1;
                m_axis_tready = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge aclk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        avg_set_t got;
        avg_set_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_avgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: x=%h y=%h z=%h",
                             got.avg_x, got.avg_y, got.avg_z);
            end else begin
                want = pending_avgs.pop_front();
                if (got.avg_x !== want.avg_x || got.avg_y !== want.avg_y
                    || got.avg_z !== want.avg_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                                 want.avg_x, want.avg_y, want.avg_z,
                                 got.avg_x, got.avg_y, got.avg_z);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("three_axis_channel_averager_tb: FAIL");
        $finish;
    end

    initial begin
        int       items;
        int       settle;
        avg_set_t typed_avgs;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        aresetn       = 1'b0;
        mismatches    = 0;
        hold_req      = 0;
        idle_on       = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            acc_sum[i] = '0;
            acc_cnt[i] = '0;
        end
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            typed_avgs.avg_x = dir_rows[r].ex_x;
            typed_avgs.avg_y = dir_rows[r].ex_y;
            typed_avgs.avg_z = dir_rows[r].ex_z;
            send_item(dir_rows[r].mode, dir_rows[r].chan, dir_rows[r].smp,
                      dir_rows[r].typed, typed_avgs);
        end

        items = 0;
        while (items < RAND_ITEMS) begin
            if (items == 300) begin
                // reads pile up behind a held result until the input stalls
                hold_req = hold_req + 1;
                for (int n = 0; n < 6; n++) begin
                    send_item(MODE_READ, 2'($urandom_range(0, 3)), 16'($urandom), 1'b0, '0);
                    repeat (3) send_random(1000);
                end
                items += 24;
            end
            if (items >= RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            send_random(12);
            items++;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;

        while (pending_avgs.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < DRAIN_CYCLES) begin
            @(posedge aclk);
            settle++;
        end
        if (mismatches == 0)
            $display("three_axis_channel_averager_tb: PASS");
        else
            $display("three_axis_channel_averager_tb: FAIL");
        $finish;
    end

endmodule
